// File: src/abb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abb_pkg: shared types and constants of the arc bounding box
// Fixed-point formats of the rotation chain, the arctangent steps and the
// side payload that travels next to the rotation cells.
// ----------------------------------------------------------------------------
package abb_pkg;

    // rotation datapath widths
    localparam int XW    = 34;   // Q30 vector lanes, signed with headroom
    localparam int ZW    = 33;   // Q24 degree residual, signed
    localparam int ZFRAC = 24;

    localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [XW-1:0] ONE_Q30         = 34'sd1073741824;
    localparam logic [31:0]          DEG_PER_RAD_Q24 = 32'd961263669;

    // arctangent of 2^-i in Q24 degrees
    function automatic logic [31:0] atan_step(input int i);
        logic [31:0] v;
        case (i)
            0:       v = 32'd754974720;
            1:       v = 32'd445687602;
            2:       v = 32'd235489089;
            3:       v = 32'd119537938;
            4:       v = 32'd60000934;
            5:       v = 32'd30029717;
            6:       v = 32'd15018523;
            7:       v = 32'd7509720;
            8:       v = 32'd3754917;
            9:       v = 32'd1877466;
            10:      v = 32'd938734;
            11:      v = 32'd469367;
            default: v = DEG_PER_RAD_Q24 >> i;
        endcase
        return v;
    endfunction

    // item data carried alongside the rotation cells
    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic [29:0]        r;
        logic [3:0]         dirs;   // axis directions 0, 90, 180, 270 inside arc
        logic [1:0]         q_s;
        logic [1:0]         q_e;
        logic               tz_s;   // start residue is zero
        logic               tz_e;   // end residue is zero
    } abb_side_t;

endpackage
`default_nettype wire

// File: src/abb_cordic_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abb_cordic_cell: one rotation step of the trig chain
// Rotates the vector by the fixed step angle toward a zero residual and
// registers the result for the next cell.
// ----------------------------------------------------------------------------
module abb_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire                              aclk,
    input  wire                              en,
    input  wire logic signed [abb_pkg::XW-1:0] x_in,
    input  wire logic signed [abb_pkg::XW-1:0] y_in,
    input  wire logic signed [abb_pkg::ZW-1:0] z_in,
    output logic signed [abb_pkg::XW-1:0]      x_reg,
    output logic signed [abb_pkg::XW-1:0]      y_reg,
    output logic signed [abb_pkg::ZW-1:0]      z_reg
);
    localparam logic signed [abb_pkg::ZW-1:0] STEP_ATAN =
        abb_pkg::ZW'(abb_pkg::atan_step(STAGE));

    logic signed [abb_pkg::XW-1:0] x_next, y_next, dx, dy;
    logic signed [abb_pkg::ZW-1:0] z_next;

    // rotate by the step angle in the direction of the residual
    always_comb begin
        dx = y_in >>> STAGE;
        dy = x_in >>> STAGE;
        if (!z_in[abb_pkg::ZW-1]) begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - STEP_ATAN;
        end else begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + STEP_ATAN;
        end
    end

    // advance to the next cell
    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

endmodule
`default_nettype wire

// File: src/arc_bounding_box.sv
`default_nettype none
// ----------------------------------------------------------------------------
// arc_bounding_box: axis-aligned bounding rectangle of a circular arc
// Pipelined endpoint trig, scaling by radius, min/max and margin widening.
// ----------------------------------------------------------------------------
// One arc enters every cycle unless the output stalls; each rectangle runs
// through the input stage, angle reduction, two rows of rotation cells (one
// cell per trig stage, start and end angle side by side), quadrant mapping,
// scaling by the radius, endpoint placement, min/max and margin stages. The
// whole pipeline stalls only while a finished rectangle waits on m_ready. Margin
// writes on cfg_wr_en take effect for beats that reach the last stage afterwards.
module arc_bounding_box #(
    parameter int ANGLE_FRAC_BITS = 8,
    parameter int TRIG_STAGES     = 16
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    input  wire logic signed [31:0] s_center_x,
    input  wire logic signed [31:0] s_center_y,
    input  wire logic [29:0]  s_radius,
    input  wire logic [16:0]  s_start_angle,
    input  wire logic [16:0]  s_end_angle,
    output logic              m_valid,
    input  wire               m_ready,
    output logic signed [31:0] m_box_min_x,
    output logic signed [31:0] m_box_min_y,
    output logic [31:0]       m_box_width,
    output logic [31:0]       m_box_height,
    input  wire               cfg_wr_en,
    input  wire logic [30:0]  cfg_wr_data
);
    localparam int XW = abb_pkg::XW;
    localparam int ZW = abb_pkg::ZW;
    localparam longint FULL    = 64'(360) << ANGLE_FRAC_BITS;
    localparam longint QUARTER = 64'(90) << ANGLE_FRAC_BITS;
    localparam int     SH      = 34;
    localparam logic [63:0] RECIP = 64'((64'd1 << SH) / FULL);
    localparam int     AW      = $clog2(FULL) + 2;
    localparam int     ZSH     = abb_pkg::ZFRAC - ANGLE_FRAC_BITS;
    localparam int     NST     = TRIG_STAGES + 7;
    localparam int     PC      = TRIG_STAGES + 1;   // first post-chain side slot

    logic en;
    logic [NST-1:0] vld_reg;
    logic [30:0]    margin_reg;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[NST-1];

    // hold the margin register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg <= 31'd65536;
        end else if (cfg_wr_en) begin
            margin_reg <= cfg_wr_data;
        end
    end

    // advance beat valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_valid};
        end
    end

    // input stage: register beat and estimate turn quotient
    logic signed [31:0] cx0_reg, cy0_reg;
    logic [29:0]        r0_reg;
    logic [16:0]        sa0_reg, ea0_reg, qs0_reg, qe0_reg;
    logic [63:0]        prod_s, prod_e;

    assign prod_s = 64'(s_start_angle) * RECIP;
    assign prod_e = 64'(s_end_angle) * RECIP;

    always_ff @(posedge aclk) begin
        if (en) begin
            cx0_reg <= s_center_x;
            cy0_reg <= s_center_y;
            r0_reg  <= s_radius;
            sa0_reg <= s_start_angle;
            ea0_reg <= s_end_angle;
            qs0_reg <= prod_s[SH+16:SH];
            qe0_reg <= prod_e[SH+16:SH];
        end
    end

    // reduction stage: angle mod full turn, quadrant, residue, axis flags
    function automatic logic [AW-1:0] reduce(input logic [16:0] a, input logic [16:0] q);
        logic [63:0] m;
        m = 64'(a) - 64'(q) * 64'(FULL);
        if (m >= 64'(FULL)) begin
            m = m - 64'(FULL);
        end
        return AW'(m);
    endfunction

    function automatic logic [1:0] quad(input logic [AW-1:0] m);
        logic [1:0] q;
        if (m >= AW'(3 * QUARTER))      q = 2'd3;
        else if (m >= AW'(2 * QUARTER)) q = 2'd2;
        else if (m >= AW'(QUARTER))     q = 2'd1;
        else                            q = 2'd0;
        return q;
    endfunction

    logic [AW-1:0] ms, me, ee, ts, te;
    logic [1:0]    qs, qe;
    logic [3:0]    dirs;
    abb_pkg::abb_side_t side_reg [TRIG_STAGES+4];
    logic signed [ZW-1:0] z0_s_reg, z0_e_reg;

    always_comb begin
        ms   = reduce(sa0_reg, qs0_reg);
        me   = reduce(ea0_reg, qe0_reg);
        qs   = quad(ms);
        qe   = quad(me);
        ts   = ms - AW'(64'(qs) * QUARTER);
        te   = me - AW'(64'(qe) * QUARTER);
        ee   = (ms > me) ? me + AW'(FULL) : me;
        dirs = '0;
        for (int k = 0; k <= 8; k++) begin
            if ((AW'(k * QUARTER) + AW'(1) >= ms) && (AW'(k * QUARTER) <= ee + AW'(1))) begin
                dirs[k % 4] = 1'b1;
            end
        end
    end

    // load the reduced angles and shift the side payload along the cells
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0].cx   <= cx0_reg;
            side_reg[0].cy   <= cy0_reg;
            side_reg[0].r    <= r0_reg;
            side_reg[0].dirs <= dirs;
            side_reg[0].q_s  <= qs;
            side_reg[0].q_e  <= qe;
            side_reg[0].tz_s <= (ts == '0);
            side_reg[0].tz_e <= (te == '0);
            z0_s_reg <= ZW'(ts) <<< ZSH;
            z0_e_reg <= ZW'(te) <<< ZSH;
            for (int j = 1; j < TRIG_STAGES + 4; j++) begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    // two rows of rotation cells, start and end angle
    logic signed [XW-1:0] xs [TRIG_STAGES+1];
    logic signed [XW-1:0] ys [TRIG_STAGES+1];
    logic signed [ZW-1:0] zs [TRIG_STAGES+1];
    logic signed [XW-1:0] xe [TRIG_STAGES+1];
    logic signed [XW-1:0] ye [TRIG_STAGES+1];
    logic signed [ZW-1:0] ze [TRIG_STAGES+1];

    assign xs[0] = abb_pkg::CORDIC_GAIN_Q30;
    assign ys[0] = '0;
    assign zs[0] = z0_s_reg;
    assign xe[0] = abb_pkg::CORDIC_GAIN_Q30;
    assign ye[0] = '0;
    assign ze[0] = z0_e_reg;

    for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_cell
        abb_cordic_cell #(.STAGE(i)) u_cell_s (
            .aclk(aclk), .en(en),
            .x_in(xs[i]), .y_in(ys[i]), .z_in(zs[i]),
            .x_reg(xs[i+1]), .y_reg(ys[i+1]), .z_reg(zs[i+1])
        );
        abb_cordic_cell #(.STAGE(i)) u_cell_e (
            .aclk(aclk), .en(en),
            .x_in(xe[i]), .y_in(ye[i]), .z_in(ze[i]),
            .x_reg(xe[i+1]), .y_reg(ye[i+1]), .z_reg(ze[i+1])
        );
    end

    // clamp and map to quadrant as magnitude and sign
    function automatic logic signed [XW-1:0] clamp(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] c;
        if (v < 0)                         c = '0;
        else if (v > abb_pkg::ONE_Q30)     c = abb_pkg::ONE_Q30;
        else                               c = v;
        return c;
    endfunction

    typedef struct packed {
        logic [30:0] cmag;
        logic        cneg;
        logic [30:0] smag;
        logic        sneg;
    } trig_t;

    function automatic trig_t map_q(input logic signed [XW-1:0] x, input logic signed [XW-1:0] y,
                                    input logic tz, input logic [1:0] q);
        logic [30:0] xm, ym;
        trig_t t;
        xm = tz ? 31'(abb_pkg::ONE_Q30) : 31'(clamp(x));
        ym = tz ? 31'd0 : 31'(clamp(y));
        case (q)
            2'd0:    t = '{cmag: xm, cneg: 1'b0, smag: ym, sneg: 1'b0};
            2'd1:    t = '{cmag: ym, cneg: 1'b1, smag: xm, sneg: 1'b0};
            2'd2:    t = '{cmag: xm, cneg: 1'b1, smag: ym, sneg: 1'b1};
            default: t = '{cmag: ym, cneg: 1'b0, smag: xm, sneg: 1'b1};
        endcase
        return t;
    endfunction

    trig_t ts_reg, te_reg, ts1_reg, te1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            ts_reg <= map_q(xs[TRIG_STAGES], ys[TRIG_STAGES],
                            side_reg[TRIG_STAGES].tz_s, side_reg[TRIG_STAGES].q_s);
            te_reg <= map_q(xe[TRIG_STAGES], ye[TRIG_STAGES],
                            side_reg[TRIG_STAGES].tz_e, side_reg[TRIG_STAGES].q_e);
        end
    end

    // scale by radius
    logic [60:0] pcs_reg, pss_reg, pce_reg, pse_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pcs_reg <= 61'(side_reg[PC].r) * 61'(ts_reg.cmag);
            pss_reg <= 61'(side_reg[PC].r) * 61'(ts_reg.smag);
            pce_reg <= 61'(side_reg[PC].r) * 61'(te_reg.cmag);
            pse_reg <= 61'(side_reg[PC].r) * 61'(te_reg.smag);
            ts1_reg <= ts_reg;
            te1_reg <= te_reg;
        end
    end

    // round and place endpoints
    function automatic logic signed [33:0] place(input logic signed [31:0] ctr,
                                                 input logic [60:0] p, input logic add);
        logic [60:0] rp;
        logic signed [33:0] v;
        rp = p + 61'd536870912;
        v  = 34'(rp[60:30]);
        return add ? 34'(ctr) + v : 34'(ctr) - v;
    endfunction

    logic signed [33:0] pxs_reg, pys_reg, pxe_reg, pye_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pxs_reg <= place(side_reg[PC+1].cx, pcs_reg, !ts1_reg.cneg);
            pys_reg <= place(side_reg[PC+1].cy, pss_reg, ts1_reg.sneg);
            pxe_reg <= place(side_reg[PC+1].cx, pce_reg, !te1_reg.cneg);
            pye_reg <= place(side_reg[PC+1].cy, pse_reg, te1_reg.sneg);
        end
    end

    // min and max over endpoints and axis points
    logic signed [33:0] cxw, cyw, rw, mnx, mxx, mny, mxy;
    logic signed [33:0] minx_reg, miny_reg;
    logic [34:0]        w_reg, h_reg;
    abb_pkg::abb_side_t sd;

    always_comb begin
        sd  = side_reg[PC+2];
        cxw = 34'(sd.cx);
        cyw = 34'(sd.cy);
        rw  = 34'(sd.r);
        mnx = (pxs_reg < pxe_reg) ? pxs_reg : pxe_reg;
        mxx = (pxs_reg > pxe_reg) ? pxs_reg : pxe_reg;
        mny = (pys_reg < pye_reg) ? pys_reg : pye_reg;
        mxy = (pys_reg > pye_reg) ? pys_reg : pye_reg;
        if (sd.dirs[1] || sd.dirs[3]) begin
            if (cxw < mnx) mnx = cxw;
            if (cxw > mxx) mxx = cxw;
        end
        if (sd.dirs[0] || sd.dirs[2]) begin
            if (cyw < mny) mny = cyw;
            if (cyw > mxy) mxy = cyw;
        end
        if (sd.dirs[0] && (cxw + rw > mxx)) mxx = cxw + rw;
        if (sd.dirs[2] && (cxw - rw < mnx)) mnx = cxw - rw;
        if (sd.dirs[1] && (cyw - rw < mny)) mny = cyw - rw;
        if (sd.dirs[3] && (cyw + rw > mxy)) mxy = cyw + rw;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            minx_reg <= mnx;
            miny_reg <= mny;
            w_reg    <= 35'(mxx - mnx);
            h_reg    <= 35'(mxy - mny);
        end
    end

    // widen by margin where a side is narrower than it, and saturate
    function automatic logic signed [31:0] sat_s(input logic signed [37:0] v);
        logic signed [31:0] o;
        if (v > 38'sd2147483647)       o = 32'sh7FFFFFFF;
        else if (v < -38'sd2147483648) o = 32'sh80000000;
        else                           o = 32'(v);
        return o;
    endfunction

    function automatic logic [31:0] sat_u(input logic [37:0] v);
        return (v > 38'd4294967295) ? 32'hFFFFFFFF : 32'(v);
    endfunction

    logic signed [37:0] mw, fx, fy;
    logic [37:0]        fw, fh;

    always_comb begin
        mw = 38'(margin_reg);
        fx = 38'(minx_reg);
        fy = 38'(miny_reg);
        fw = 38'(w_reg);
        fh = 38'(h_reg);
        if (fw < 38'(margin_reg)) begin
            fx = fx - mw;
            fw = fw + 38'(margin_reg) + 38'(margin_reg);
        end
        if (fh < 38'(margin_reg)) begin
            fy = fy - mw;
            fh = fh + 38'(margin_reg) + 38'(margin_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_box_min_x  <= sat_s(fx);
            m_box_min_y  <= sat_s(fy);
            m_box_width  <= sat_u(fw);
            m_box_height <= sat_u(fh);
        end
    end

endmodule
`default_nettype wire

// File: src/abb_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abb_checker: port-level checks of the arc bounding box
// Watches the handshakes on the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
module abb_checker (
    input wire              aclk,
    input wire              aresetn,
    input wire              s_ready,
    input wire              m_valid,
    input wire              m_ready,
    input wire logic [31:0] m_box_width,
    input wire logic [31:0] m_box_min_x
);
    // the pipeline frees input space exactly when the output moves or is empty
    a_ready_follows_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("s_ready does not track output stall");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // a stalled result beat holds its data
    a_hold_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_box_width) && $stable(m_box_min_x)))
        else $error("result beat changed while stalled");

endmodule

bind arc_bounding_box abb_checker u_abb_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready), .m_valid(m_valid),
    .m_ready(m_ready), .m_box_width(m_box_width), .m_box_min_x(m_box_min_x)
);
`default_nettype wire
